// ----- rtl/csg_pkg.sv -----
// Shared types, constants and arithmetic helpers of the chirp symbol generator.
`default_nettype none

package csg_pkg;

  localparam int POS_W     = 12;
  localparam int OFFSET_W  = 12;
  localparam int ANG_W     = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int LOG2_W    = 4;
  localparam int Q_W       = 31;

  localparam logic [CFG_IDX_W-1:0] REG_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BW   = 2'd1;

  localparam logic [LOG2_W-1:0] LOG2_RESET = 4'd7;
  localparam logic [LOG2_W-1:0] LOG2_MIN   = 4'd5;
  localparam logic [CFG_W-1:0]  BW_RESET   = 32'h8000_0000;

  localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [Q_W-1:0]   Q30_ONE      = 31'h4000_0000;

  localparam logic [Q_W-1:0] SIN_COEF [5] = '{
    31'd1686629713, 31'd693598670, 31'd85569304, 31'd5026995, 31'd172271
  };

  typedef struct packed {
    logic             valid;
    logic             down;
    logic             last;
    logic [POS_W-1:0] position;
  } ctl_t;

  function automatic logic [Q_W-1:0] mul_q30(input logic [Q_W-1:0] a,
                                             input logic [Q_W-1:0] b);
    logic [2*Q_W-1:0] prod;
    prod = a * b;
    return prod[2*Q_W-2:Q_W-1];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/chirp_symbol_generator.sv -----
// Chirp symbol generator top level: one I/Q sample beat out for each input beat taken.
// Throughput: one beat per cycle; the input stalls only while a held result meets output stall.
// The phase accumulator closes its loop through a single register; every multiplier product is registered.
// Reset clears the phase, the sample count and all stage valids, and loads log2 7 and bandwidth 2^31.
`default_nettype none

module chirp_symbol_generator import csg_pkg::*; #(
  parameter int MAX_LOG2_SAMPLES = 12,
  parameter int PHASE_BITS       = 32,
  parameter int SAMPLE_BITS      = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic        [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic        [CFG_W-1:0]       cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          action_i,
  input  wire logic                          symbol_start_i,
  input  wire logic        [OFFSET_W-1:0]    bin_offset_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed      [SAMPLE_BITS-1:0] i_sample_o,
  output logic signed      [SAMPLE_BITS-1:0] q_sample_o,
  output logic             [POS_W-1:0]       sample_position_o,
  output logic                               last_of_symbol_o
);

  localparam int CTL_DEPTH = 6;

  logic [LOG2_W-1:0]      log2_q;
  logic [CFG_W-1:0]       bw_q;
  logic                   en;
  logic                   accept;
  logic [ANG_W-1:0]       ang;
  logic [ANG_W-1:0]       ang_cos;
  ctl_t                   ctl_ph;
  ctl_t                   ctl_q [CTL_DEPTH];
  logic [SAMPLE_BITS-1:0] cos_smp;
  logic [SAMPLE_BITS-1:0] sin_smp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_q <= LOG2_RESET;
      bw_q   <= BW_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LOG2: log2_q <= cfg_wdata_i[LOG2_W-1:0];
        REG_BW:   bw_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign en         = !(ctl_q[CTL_DEPTH-1].valid && out_stall_i);
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;

  csg_phase #(
    .MAX_LOG2_SAMPLES(MAX_LOG2_SAMPLES),
    .PHASE_BITS      (PHASE_BITS)
  ) u_phase (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .accept_i      (accept),
    .action_i      (action_i),
    .symbol_start_i(symbol_start_i),
    .bin_offset_i  (bin_offset_i),
    .log2_cfg_i    (log2_q),
    .bw_cfg_i      (bw_q),
    .ang_o         (ang),
    .ctl_o         (ctl_ph)
  );

  assign ang_cos = ang + QUARTER_TURN;

  csg_sine #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_cos (
    .clk_i   (clk_i),
    .en_i    (en),
    .ang_i   (ang_cos),
    .negate_i(1'b0),
    .sample_o(cos_smp)
  );

  csg_sine #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_sin (
    .clk_i   (clk_i),
    .en_i    (en),
    .ang_i   (ang),
    .negate_i(ctl_ph.down),
    .sample_o(sin_smp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CTL_DEPTH; i++) begin
        ctl_q[i] <= '0;
      end
    end else if (en) begin
      ctl_q[0] <= ctl_ph;
      for (int i = 1; i < CTL_DEPTH; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  assign out_valid_o       = ctl_q[CTL_DEPTH-1].valid;
  assign i_sample_o        = $signed(cos_smp);
  assign q_sample_o        = $signed(sin_smp);
  assign sample_position_o = ctl_q[CTL_DEPTH-1].position;
  assign last_of_symbol_o  = ctl_q[CTL_DEPTH-1].last;

endmodule

`default_nettype wire

// ----- rtl/csg_phase.sv -----
// Sample counter, increment multiplier and phase accumulator of the chirp symbol generator.
`default_nettype none

module csg_phase import csg_pkg::*; #(
  parameter int MAX_LOG2_SAMPLES = 12,
  parameter int PHASE_BITS       = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                accept_i,
  input  wire logic                action_i,
  input  wire logic                symbol_start_i,
  input  wire logic [OFFSET_W-1:0] bin_offset_i,
  input  wire logic [LOG2_W-1:0]   log2_cfg_i,
  input  wire logic [CFG_W-1:0]    bw_cfg_i,
  output logic      [ANG_W-1:0]    ang_o,
  output ctl_t                     ctl_o
);

  localparam int CNT_W  = MAX_LOG2_SAMPLES;
  localparam int PROD_W = PHASE_BITS + CNT_W;
  localparam int UP_SH  = (PHASE_BITS > ANG_W) ? PHASE_BITS - ANG_W : 0;
  localparam int DN_SH  = (PHASE_BITS < ANG_W) ? ANG_W - PHASE_BITS : 0;

  logic [LOG2_W-1:0]     lg;
  logic [CNT_W-1:0]      nmask;
  logic [CNT_W-1:0]      idx;
  logic [CNT_W-1:0]      off;
  logic [CNT_W-1:0]      k_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [PHASE_BITS-1:0] bwp;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [PHASE_BITS-1:0] base;
  logic [PHASE_BITS-1:0] inc;
  logic [ANG_W-1:0]      ang_d;
  logic [ANG_W-1:0]      ang_q;
  logic [CNT_W-1:0]      k0_q;
  logic [PROD_W-1:0]     prod1_q;
  logic                  start0_q, start1_q;
  ctl_t                  ctl_d, ctl0_q, ctl1_q, ctl2_q;

  always_comb begin
    if (log2_cfg_i < LOG2_MIN) begin
      lg = LOG2_MIN;
    end else if (log2_cfg_i > LOG2_W'(MAX_LOG2_SAMPLES)) begin
      lg = LOG2_W'(MAX_LOG2_SAMPLES);
    end else begin
      lg = log2_cfg_i;
    end
  end

  assign nmask   = ~({CNT_W{1'b1}} << lg);
  assign idx     = (symbol_start_i ? '0 : count_q) & nmask;
  assign off     = action_i ? '0 : CNT_W'(bin_offset_i);
  assign k_d     = (off + idx) & nmask;
  assign count_d = (idx + 1'b1) & nmask;

  always_comb begin
    ctl_d          = '0;
    ctl_d.valid    = accept_i;
    ctl_d.down     = action_i;
    ctl_d.last     = (idx == nmask);
    ctl_d.position = POS_W'(idx);
  end

  if (PHASE_BITS >= ANG_W) begin : g_wide
    assign bwp   = PHASE_BITS'(bw_cfg_i) << UP_SH;
    assign ang_d = base[PHASE_BITS-1 -: ANG_W];
  end else begin : g_narrow
    assign bwp   = PHASE_BITS'(bw_cfg_i >> DN_SH);
    assign ang_d = ANG_W'(base) << DN_SH;
  end

  assign base    = start1_q ? '0 : phase_q;
  assign inc     = PHASE_BITS'(prod1_q >> lg) - (bwp >> 1);
  assign phase_d = base + inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      phase_q <= '0;
      ctl0_q  <= '0;
      ctl1_q  <= '0;
      ctl2_q  <= '0;
    end else begin
      if (accept_i) begin
        count_q <= count_d;
      end
      if (en_i && ctl1_q.valid) begin
        phase_q <= phase_d;
      end
      if (en_i) begin
        ctl0_q <= ctl_d;
        ctl1_q <= ctl0_q;
        ctl2_q <= ctl1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k0_q     <= k_d;
      start0_q <= symbol_start_i;
      prod1_q  <= bwp * k0_q;
      start1_q <= start0_q;
      ang_q    <= ang_d;
    end
  end

  assign ang_o = ang_q;
  assign ctl_o = ctl2_q;

endmodule

`default_nettype wire

// ----- rtl/csg_sine.sv -----
// Pipelined quarter-wave polynomial sine of a 32-bit angle, rounded and saturated.
`default_nettype none

module csg_sine import csg_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic [ANG_W-1:0]       ang_i,
  input  wire logic                   negate_i,
  output logic      [SAMPLE_BITS-1:0] sample_o
);

  localparam int                     RND_SH   = Q_W - SAMPLE_BITS;
  localparam int                     MW       = SAMPLE_BITS + 1;
  localparam logic [ANG_W-1:0]       RND_HALF = ANG_W'(1) << (RND_SH - 1);
  localparam logic [MW-1:0]          MAG_LIM  = MW'((1 << (SAMPLE_BITS - 1)) - 1);

  logic [1:0]             quad;
  logic [Q_W-1:0]         frac;
  logic [Q_W-1:0]         x_d;
  logic [Q_W-1:0]         x_q  [5];
  logic [Q_W-1:0]         x2_q [4];
  logic [Q_W-1:0]         p_q  [1:4];
  logic                   neg_q [5];
  logic [Q_W-1:0]         v;
  logic [ANG_W-1:0]       rsum;
  logic [MW-1:0]          rnd;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS-1:0] sample_d;
  logic [SAMPLE_BITS-1:0] sample_q;

  assign quad = ang_i[ANG_W-1 -: 2];
  assign frac = {1'b0, ang_i[ANG_W-3:0]};
  assign x_d  = quad[0] ? (Q30_ONE - frac) : frac;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= x_d;
      x2_q[0]  <= mul_q30(x_d, x_d);
      neg_q[0] <= quad[1] ^ negate_i;
    end
  end

  for (genvar j = 1; j <= 4; j++) begin : g_horner
    logic [Q_W-1:0] p_prev;
    if (j == 1) begin : g_first
      assign p_prev = SIN_COEF[4];
    end else begin : g_next
      assign p_prev = p_q[j-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[j]   <= SIN_COEF[4-j] - mul_q30(x2_q[j-1], p_prev);
        x_q[j]   <= x_q[j-1];
        neg_q[j] <= neg_q[j-1];
      end
    end
    if (j < 4) begin : g_x2
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x2_q[j] <= x2_q[j-1];
        end
      end
    end
  end

  assign v        = mul_q30(x_q[4], p_q[4]);
  assign rsum     = {1'b0, v} + RND_HALF;
  assign rnd      = rsum[ANG_W-1:RND_SH];
  assign mag      = (rnd > MAG_LIM) ? MAG_LIM[SAMPLE_BITS-1:0] : rnd[SAMPLE_BITS-1:0];
  assign sample_d = neg_q[4] ? -mag : mag;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sample_q <= sample_d;
    end
  end

  assign sample_o = sample_q;

endmodule

`default_nettype wire

// ----- rtl/csg_checker.sv -----
// Port-level assertions for the chirp symbol generator and their bind to the top level.
`default_nettype none

module csg_checker import csg_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic signed [SAMPLE_BITS-1:0] i_sample_o,
  input wire logic signed [SAMPLE_BITS-1:0] q_sample_o,
  input wire logic        [POS_W-1:0]       sample_position_o,
  input wire logic                          last_of_symbol_o
);

  localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // The input is held back only while a finished result waits on a stalled output.
  a_stall_only_when_blocked: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && out_stall_i) |-> !in_stall_o
  ) else $error("input stalled while the output was free");

  // A stalled output beat holds its payload.
  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(i_sample_o) && $stable(q_sample_o) &&
      $stable(sample_position_o) && $stable(last_of_symbol_o)
  ) else $error("stalled output beat changed");

  // Samples are saturated symmetrically, so the most negative code never appears.
  a_saturated: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (i_sample_o != MOST_NEG) && (q_sample_o != MOST_NEG)
  ) else $error("sample outside the saturated range");

  // A symbol holds at least 32 samples, so its last position has its low five bits set.
  a_last_position: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_symbol_o |-> sample_position_o[4:0] == 5'h1f
  ) else $error("last sample flagged at an impossible position");

endmodule

bind chirp_symbol_generator csg_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_csg_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .i_sample_o       (i_sample_o),
  .q_sample_o       (q_sample_o),
  .sample_position_o(sample_position_o),
  .last_of_symbol_o (last_of_symbol_o)
);

`default_nettype wire

// ----- tb/sv/chirp_symbol_checker.sv -----
// Checker for the chirp symbol generator: predicts every output beat and compares it.
`timescale 1ns / 100ps

module chirp_symbol_checker import csg_pkg::*; #(
  parameter logic DOWN_CODE = 1'b1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 action_i,
  input  logic                 symbol_start_i,
  input  logic [OFFSET_W-1:0]  bin_offset_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic signed [15:0]   i_sample_i,
  input  logic signed [15:0]   q_sample_i,
  input  logic [POS_W-1:0]     sample_position_i,
  input  logic                 last_of_symbol_i,
  output int                   pending_o,
  output int                   fail_count_o
);

  localparam int          MAX_LOG2  = 12;
  localparam logic [63:0] SINE_PEAK = 64'd32767;
  localparam logic [63:0] POLY_COEF [5] = '{
    64'd1686629713, 64'd693598670, 64'd85569304, 64'd5026995, 64'd172271
  };

  typedef struct packed {
    logic [15:0]      i_val;
    logic [15:0]      q_val;
    logic [POS_W-1:0] pos;
    logic             last;
  } chirp_sample_t;

  chirp_sample_t    samples_due [$];
  chirp_sample_t    due;
  logic [31:0]      phase_acc;
  logic [POS_W-1:0] sample_count;
  logic [LOG2_W-1:0] log2_reg;
  logic [CFG_W-1:0] bw_reg;
  int               fails;

  assign fail_count_o = fails;

  // Magnitude of sin(pi/2 * x) for x in Q30, rounded to Q15 and saturated.
  function automatic logic [63:0] quarter_wave(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] v;
    x2 = (x * x) >> 30;
    p = POLY_COEF[4];
    for (int j = 3; j >= 0; j--) p = POLY_COEF[j] - ((x2 * p) >> 30);
    p = (x * p) >> 30;
    v = (p + 64'd16384) >> 15;
    return (v > SINE_PEAK) ? SINE_PEAK : v;
  endfunction

  function automatic logic [15:0] sine_of(input logic [31:0] angle, input logic negate);
    logic [63:0] frac;
    logic [63:0] mag;
    frac = {34'd0, angle[29:0]};
    mag = quarter_wave(angle[30] ? (64'd1 << 30) - frac : frac);
    return (angle[31] ^ negate) ? 16'd0 - mag[15:0] : mag[15:0];
  endfunction

  function automatic chirp_sample_t advance_chirp(input logic down, input logic restart,
                                                  input logic [OFFSET_W-1:0] offset_in);
    logic [LOG2_W-1:0] lg;
    logic [POS_W-1:0]  nmask;
    logic [POS_W-1:0]  idx;
    logic [POS_W-1:0]  k;
    logic [POS_W-1:0]  offset;
    logic [63:0]       scaled;
    chirp_sample_t     s;
    lg = (log2_reg < LOG2_MIN) ? LOG2_MIN :
         (log2_reg > MAX_LOG2) ? LOG2_W'(MAX_LOG2) : log2_reg;
    nmask = POS_W'((32'd1 << lg) - 32'd1);
    offset = down ? '0 : offset_in;
    if (restart) begin
      phase_acc = '0;
      sample_count = '0;
    end
    idx = sample_count & nmask;
    s.i_val = sine_of(phase_acc + QUARTER_TURN, 1'b0);
    s.q_val = sine_of(phase_acc, down);
    s.pos = idx;
    s.last = (idx == nmask);
    k = (offset + idx) & nmask;
    scaled = ({32'd0, bw_reg} * {52'd0, k}) >> lg;
    phase_acc = phase_acc + scaled[31:0] - {1'b0, bw_reg[31:1]};
    sample_count = (idx + 1'b1) & nmask;
    return s;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc = '0;
      sample_count = '0;
      log2_reg = LOG2_RESET;
      bw_reg = BW_RESET;
      samples_due.delete();
      fails = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_LOG2) log2_reg = cfg_wdata_i[LOG2_W-1:0];
        else if (cfg_index_i == REG_BW) bw_reg = cfg_wdata_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (samples_due.size() == 0) begin
          $error("output beat arrived with no sample due");
          fails++;
        end else begin
          due = samples_due.pop_front();
          check_field("i_sample", $signed(due.i_val), i_sample_i);
          check_field("q_sample", $signed(due.q_val), q_sample_i);
          check_field("sample_position", due.pos, sample_position_i);
          check_field("last_of_symbol", due.last, last_of_symbol_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        samples_due.push_back(advance_chirp(action_i == DOWN_CODE, symbol_start_i,
                                            bin_offset_i));
      end
      pending_o <= samples_due.size();
    end
  end

endmodule

// ----- tb/sv/chirp_symbol_generator_test.sv -----
// Top of the chirp symbol generator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module chirp_symbol_generator_test import csg_pkg::*;;

  localparam logic ACT_UP   = 1'b0;
  localparam logic ACT_DOWN = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int MAX_LOG2     = 12;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 action_i;
  logic                 symbol_start_i;
  logic [OFFSET_W-1:0]  bin_offset_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic signed [15:0]   i_sample_o;
  logic signed [15:0]   q_sample_o;
  logic [POS_W-1:0]     sample_position_o;
  logic                 last_of_symbol_o;

  int pending;
  int fail_count;
  int stall_left  = 0;
  int quiet_count = 0;
  bit idle_on;

  chirp_symbol_generator u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .symbol_start_i    (symbol_start_i),
    .bin_offset_i      (bin_offset_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .i_sample_o        (i_sample_o),
    .q_sample_o        (q_sample_o),
    .sample_position_o (sample_position_o),
    .last_of_symbol_o  (last_of_symbol_o)
  );

  chirp_symbol_checker #(.DOWN_CODE(ACT_DOWN)) u_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .action_i          (action_i),
    .symbol_start_i    (symbol_start_i),
    .bin_offset_i      (bin_offset_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .i_sample_i        (i_sample_o),
    .q_sample_i        (q_sample_o),
    .sample_position_i (sample_position_o),
    .last_of_symbol_i  (last_of_symbol_o),
    .pending_o         (pending),
    .fail_count_o      (fail_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_count <= 0;
    end else if (quiet_count == QUIET_LIMIT) begin
      $display("chirp_symbol_generator_test: errors");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  task automatic send_beat(input logic act, input logic start,
                           input logic [OFFSET_W-1:0] offset);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    symbol_start_i <= start;
    bin_offset_i <= offset;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Registers change only once every sample in flight has come out.
  task automatic write_regs(input logic [LOG2_W-1:0] lg, input logic [CFG_W-1:0] bw,
                            input bit spare);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_LOG2;
    cfg_wdata_i <= ($urandom() << LOG2_W) | lg;
    @(posedge clk_i);
    cfg_index_i <= REG_BW;
    cfg_wdata_i <= bw;
    if (spare) begin
      @(posedge clk_i);
      cfg_index_i <= REG_SPARE_LO;
      cfg_wdata_i <= $urandom();
      @(posedge clk_i);
      cfg_index_i <= REG_SPARE_HI;
      cfg_wdata_i <= $urandom();
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly whole symbols opened by a start beat; some cut short, some run past the wrap.
  task automatic run_phase(input logic [LOG2_W-1:0] lg, input logic [CFG_W-1:0] bw,
                           input int beats, input bit spare, input bit quiet);
    int n;
    int r;
    int sym_len;
    int sent;
    logic down;
    logic start;
    logic [OFFSET_W-1:0] offset;
    bit first;
    write_regs(lg, bw, spare);
    n = 1 << ((lg < LOG2_MIN) ? LOG2_MIN : (lg > MAX_LOG2) ? MAX_LOG2 : lg);
    sent = 0;
    first = 1;
    while (sent < beats) begin
      r = $urandom_range(0, 19);
      if (r < 14) sym_len = n;
      else if (r < 17) sym_len = $urandom_range(1, n - 1);
      else sym_len = n + $urandom_range(1, n);
      down = ($urandom_range(0, 3) == 0);
      offset = OFFSET_W'($urandom());
      idle_on <= !quiet && ($urandom_range(0, 3) != 0);
      for (int j = 0; j < sym_len && sent < beats; j++) begin
        start = (j == 0) && !first;
        if ($urandom_range(0, 31) == 0) start = ~start;
        if ($urandom_range(0, 63) == 0) offset = OFFSET_W'($urandom());
        send_beat(down ? ACT_DOWN : ACT_UP, start, offset);
        sent++;
      end
      first = 0;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_LOG2;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    action_i = ACT_UP;
    symbol_start_i = 1'b0;
    bin_offset_i = '0;
    out_stall_i = 1'b0;
    idle_on = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: offsets at both extremes and beyond N, down chirps with
    // an offset that must be ignored, and restarts in the middle of a symbol.
    send_beat(ACT_UP, 1'b1, 12'd0);
    send_beat(ACT_UP, 1'b0, 12'hFFF);
    send_beat(ACT_UP, 1'b0, 12'd0);
    send_beat(ACT_UP, 1'b0, 12'd127);
    send_beat(ACT_UP, 1'b0, 12'd128);
    send_beat(ACT_DOWN, 1'b0, 12'hFFF);
    send_beat(ACT_DOWN, 1'b0, 12'd0);
    send_beat(ACT_UP, 1'b1, 12'hAAA);
    send_beat(ACT_UP, 1'b0, 12'h555);
    send_beat(ACT_DOWN, 1'b1, 12'hFFF);
    send_beat(ACT_DOWN, 1'b0, 12'h800);
    send_beat(ACT_UP, 1'b1, 12'h07F);
    repeat (8) send_beat(ACT_UP, 1'b0, 12'd1);

    run_phase(4'd5, 32'h8000_0000, 250, 1'b0, 1'b0);
    run_phase(4'd6, $urandom(), 200, 1'b0, 1'b0);
    run_phase(4'd0, 32'hFFFF_FFFF, 150, 1'b1, 1'b0);
    run_phase(4'd15, 32'h0000_0000, 100, 1'b0, 1'b0);
    run_phase(4'd8, 32'h0000_0001, 150, 1'b0, 1'b0);
    run_phase(4'd12, $urandom(), 250, 1'b0, 1'b0);
    run_phase(4'd4, $urandom(), 150, 1'b1, 1'b0);
    run_phase(4'd7, $urandom(), 200, 1'b0, 1'b0);
    run_phase(4'd13, 32'h8000_0000, 100, 1'b0, 1'b0);
    run_phase(LOG2_W'($urandom_range(5, 9)), $urandom(), 200, 1'b0, 1'b1);

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("chirp_symbol_generator_test: clean");
    end else begin
      $display("chirp_symbol_generator_test: errors");
    end
    $finish;
  end

endmodule

// ----- chirp_symbol_generator.f -----
rtl/csg_pkg.sv
rtl/csg_phase.sv
rtl/csg_sine.sv
rtl/chirp_symbol_generator.sv
rtl/csg_checker.sv
tb/sv/chirp_symbol_checker.sv
tb/sv/chirp_symbol_generator_test.sv
